// ===== hw/rtl/mbrtu_pkg.sv =====
// Package for the Modbus RTU master: item types, codes and constants.
// Used by modbus_rtu_master_transaction; depends on nothing.
package mbrtu_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [1:0] KIND_TX  = 2'd0;
  localparam logic [1:0] KIND_REG = 2'd1;
  localparam logic [1:0] KIND_ST  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ADDR   = 2'd1;
  localparam logic [1:0] ST_EXC    = 2'd2;
  localparam logic [1:0] ST_FORMAT = 2'd3;

  localparam logic [2:0] CFG_SLAVE   = 3'd0;
  localparam logic [2:0] CFG_RSTART  = 3'd1;
  localparam logic [2:0] CFG_RCOUNT  = 3'd2;
  localparam logic [2:0] CFG_GAP     = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT = 3'd4;

  localparam logic [7:0]  FN_READ   = 8'h03;
  localparam logic [7:0]  FN_WRITE  = 8'h06;
  localparam logic [7:0]  EXC_BIT   = 8'h80;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  rx_byte;
    logic [15:0] write_address;
    logic [15:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  tx_byte;
    logic [4:0]  reg_index;
    logic [15:0] reg_value;
    logic [1:0]  status;
    logic [7:0]  exception_code;
    logic        last;
  } out_item_t;

  // One CRC bit step.
  function automatic logic [15:0] crc_bit(input logic [15:0] c);
    crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

endpackage

// ===== hw/rtl/mbrtu_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module mbrtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/modbus_rtu_master_transaction.sv =====
// Modbus RTU master transaction engine, top level.
// Uses mbrtu_pkg and mbrtu_ram (receive buffer).
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/in_stall   | mbrtu_pkg::in_item_t
//  out_    | output    | out_valid/out_stall | mbrtu_pkg::out_item_t
//  cfg_    | input     | cfg_we           | cfg_index, cfg_data
//
// A start item runs the 6 header bytes through one shared CRC step, bit by bit, sends
// the 8 frame bytes one a cycle while the output is not stalled, then clears the buffer
// one entry a cycle. A byte or tick that finishes reception then reads the buffer byte
// by byte: the header, then each register's bytes, then the status. Reset is synchronous,
// active low, and leaves the block idle. A stalled output holds the engine in place,
// except that the buffer clear runs on.
module modbus_rtu_master_transaction #(
  parameter int BUF_DEPTH = 256,
  parameter int MAX_REGS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mbrtu_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mbrtu_pkg::out_item_t  out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int RW = $clog2(MAX_REGS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CRC   = 4'd1;
  localparam logic [3:0] S_SEND  = 4'd2;
  localparam logic [3:0] S_CLEAR = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;  // issue buffer read
  localparam logic [3:0] S_RW    = 4'd5;  // read data arrives
  localparam logic [3:0] S_EMIT  = 4'd6;
  localparam logic [3:0] S_WAIT  = 4'd7;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_READ = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;

  logic [7:0]  slave_r;
  logic [15:0] rstart_r, gap_r, tmo_r;
  logic [5:0]  rcount_r;

  logic [3:0]  st_r, st_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [7:0]  frame_r [8];
  logic [7:0]  frame_nxt [8];
  logic [2:0]  fidx_r, fidx_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [CW-1:0] rxc_r, rxc_nxt;
  logic [15:0] sil_r, sil_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [9:0]  pos_r, pos_nxt;   // buffer byte position during checking
  logic [7:0]  b1_r, b1_nxt, hi_r, hi_nxt;
  logic [RW-1:0] ri_r, ri_nxt;
  logic        outv_r, outv_nxt;
  mbrtu_pkg::out_item_t outd_r, outd_nxt;

  logic [RW-1:0] cnt;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wd, ram_rd, bval;
  logic          pos_ok_r, pos_ok_nxt;
  logic [7:0]    b0_r, b0_nxt;

  assign cnt = (rcount_r > 6'(MAX_REGS)) ? RW'(MAX_REGS) : RW'(rcount_r);
  assign bval = pos_ok_r ? ram_rd : 8'd0;

  mbrtu_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_buf (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  assign in_stall  = (st_r != S_IDLE) || outv_r;
  assign out_valid = outv_r;
  assign out_data  = outd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r <= 8'd1; rstart_r <= 16'd9; rcount_r <= 6'd11;
      gap_r <= 16'd50; tmo_r <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        mbrtu_pkg::CFG_SLAVE:   slave_r  <= cfg_data[7:0];
        mbrtu_pkg::CFG_RSTART:  rstart_r <= cfg_data;
        mbrtu_pkg::CFG_RCOUNT:  rcount_r <= cfg_data[5:0];
        mbrtu_pkg::CFG_GAP:     gap_r    <= cfg_data;
        mbrtu_pkg::CFG_TIMEOUT: tmo_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic mbrtu_pkg::out_item_t mk(input logic [1:0] k, input logic [7:0] tx,
      input logic [4:0] ix, input logic [15:0] v, input logic [1:0] s,
      input logic [7:0] e, input logic l);
    mbrtu_pkg::out_item_t o;
    o.result_kind = k; o.tx_byte = tx; o.reg_index = ix; o.reg_value = v;
    o.status = s; o.exception_code = e; o.last = l;
    return o;
  endfunction

  always_comb begin
    logic [1:0] stv;
    logic [9:0] need;
    st_nxt = st_r; ph_nxt = ph_r; frame_nxt = frame_r; fidx_nxt = fidx_r;
    bit_nxt = bit_r; crc_nxt = crc_r; rxc_nxt = rxc_r; sil_nxt = sil_r;
    clr_nxt = clr_r; pos_nxt = pos_r; b1_nxt = b1_r; hi_nxt = hi_r; ri_nxt = ri_r;
    b0_nxt = b0_r; pos_ok_nxt = pos_ok_r;
    outv_nxt = outv_r && out_stall; outd_nxt = outd_r;
    ram_we = 1'b0; ram_addr = pos_r[AW-1:0]; ram_wd = 8'd0;
    stv = mbrtu_pkg::ST_OK;
    need = {cnt, 1'b0} + 10'd0;
    case (st_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          case (in_data.op)
            mbrtu_pkg::OP_READ, mbrtu_pkg::OP_WRITE: begin
              frame_nxt[0] = slave_r;
              if (in_data.op == mbrtu_pkg::OP_READ) begin
                frame_nxt[1] = mbrtu_pkg::FN_READ;
                {frame_nxt[2], frame_nxt[3]} = rstart_r;
                {frame_nxt[4], frame_nxt[5]} = 16'(cnt);
                ph_nxt = PH_READ;
              end else begin
                frame_nxt[1] = mbrtu_pkg::FN_WRITE;
                {frame_nxt[2], frame_nxt[3]} = in_data.write_address;
                {frame_nxt[4], frame_nxt[5]} = in_data.write_value;
                ph_nxt = PH_WRITE;
              end
              crc_nxt = mbrtu_pkg::CRC_INIT ^ {8'd0, slave_r};
              fidx_nxt = 3'd0; bit_nxt = 3'd0; st_nxt = S_CRC;
            end
            mbrtu_pkg::OP_BYTE: begin
              if (ph_r != PH_IDLE) begin
                ram_we = (rxc_r < CW'(BUF_DEPTH));
                ram_addr = rxc_r[AW-1:0];
                ram_wd = in_data.rx_byte;
                rxc_nxt = rxc_r + 1'b1;
                sil_nxt = 16'd0;
                if (rxc_r + 1'b1 >= CW'(BUF_DEPTH)) begin
                  pos_nxt = 10'd0; st_nxt = S_RD;
                end
              end
            end
            default: begin
              if (ph_r != PH_IDLE) begin
                if (sil_r != 16'hFFFF) sil_nxt = sil_r + 1'b1;
                if (sil_nxt >= tmo_r || (rxc_r != '0 && sil_nxt > gap_r)) begin
                  pos_nxt = 10'd0; st_nxt = S_RD;
                end
              end
            end
          endcase
        end
      end
      S_CRC: begin
        crc_nxt = mbrtu_pkg::crc_bit(crc_r);
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 3'd7) begin
          if (fidx_r == 3'd5) begin
            frame_nxt[6] = crc_nxt[7:0];
            frame_nxt[7] = crc_nxt[15:8];
            fidx_nxt = 3'd0; st_nxt = S_SEND;
          end else begin
            fidx_nxt = fidx_r + 1'b1;
            crc_nxt = crc_nxt ^ {8'd0, frame_r[fidx_r + 1'b1]};
          end
        end
      end
      S_SEND: begin
        if (!outv_nxt) begin
          outv_nxt = 1'b1;
          outd_nxt = mk(mbrtu_pkg::KIND_TX, frame_r[fidx_r], 5'd0, 16'd0,
                        mbrtu_pkg::ST_OK, 8'd0, fidx_r == 3'd7);
          fidx_nxt = fidx_r + 1'b1;
          if (fidx_r == 3'd7) begin
            clr_nxt = '0; st_nxt = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        ram_we = 1'b1; ram_addr = clr_r; ram_wd = 8'd0;
        clr_nxt = clr_r + 1'b1;
        rxc_nxt = '0; sil_nxt = 16'd0;
        if (clr_r == AW'(BUF_DEPTH - 1)) st_nxt = S_IDLE;
      end
      S_RD: begin
        ram_addr = pos_r[AW-1:0];
        pos_ok_nxt = ({1'b0, pos_r} < 11'(BUF_DEPTH));
        st_nxt = S_RW;
      end
      S_RW: begin
        // bval is byte at pos_r; positions 0,1,2 header, then register pairs.
        st_nxt = S_RD;
        pos_nxt = pos_r + 1'b1;
        if (pos_r == 10'd0) b0_nxt = bval;
        else if (pos_r == 10'd1) b1_nxt = bval;
        else if (pos_r == 10'd2) begin
          if (ph_r == PH_WRITE) begin
            if (b0_r != slave_r) stv = mbrtu_pkg::ST_ADDR;
            else if ((b1_r & mbrtu_pkg::EXC_BIT) != 8'd0) stv = mbrtu_pkg::ST_EXC;
            outd_nxt = mk(mbrtu_pkg::KIND_ST, 8'd0, 5'd0, 16'd0, stv,
                          (stv == mbrtu_pkg::ST_EXC) ? bval : 8'd0, 1'b1);
            st_nxt = S_EMIT; ph_nxt = PH_IDLE;
          end else if (b1_r != mbrtu_pkg::FN_READ || {2'd0, bval} < need) begin
            outd_nxt = mk(mbrtu_pkg::KIND_ST, 8'd0, 5'd0, 16'd0,
                          mbrtu_pkg::ST_FORMAT, 8'd0, 1'b1);
            st_nxt = S_EMIT; ph_nxt = PH_IDLE;
          end else begin
            ri_nxt = '0;
            if (cnt == '0) begin
              outd_nxt = mk(mbrtu_pkg::KIND_ST, 8'd0, 5'd0, 16'd0,
                            mbrtu_pkg::ST_OK, 8'd0, 1'b1);
              st_nxt = S_EMIT; ph_nxt = PH_IDLE;
            end
          end
        end else if (pos_r[0]) hi_nxt = bval;
        else if (!outv_nxt) begin
          outd_nxt = mk(mbrtu_pkg::KIND_REG, 8'd0, 5'(ri_r), {hi_r, bval},
                        mbrtu_pkg::ST_OK, 8'd0, 1'b0);
          st_nxt = S_EMIT;
        end else begin
          // The previous register item is still stalled; the read data stays put.
          st_nxt = S_RW; pos_nxt = pos_r;
        end
      end
      S_EMIT: begin
        if (!outv_nxt) begin
          outv_nxt = 1'b1;
          if (outd_r.result_kind == mbrtu_pkg::KIND_REG) begin
            ri_nxt = ri_r + 1'b1;
            if (ri_r + 1'b1 == cnt) st_nxt = S_WAIT;
            else st_nxt = S_RD;
          end else st_nxt = S_IDLE;
        end
      end
      S_WAIT: begin
        if (!outv_nxt) begin
          outv_nxt = 1'b1;
          outd_nxt = mk(mbrtu_pkg::KIND_ST, 8'd0, 5'd0, 16'd0,
                        mbrtu_pkg::ST_OK, 8'd0, 1'b1);
          ph_nxt = PH_IDLE; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= PH_IDLE; outv_r <= 1'b0;
      rxc_r <= '0; sil_r <= 16'd0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; outv_r <= outv_nxt;
      rxc_r <= rxc_nxt; sil_r <= sil_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt; fidx_r <= fidx_nxt; bit_r <= bit_nxt; crc_r <= crc_nxt;
    clr_r <= clr_nxt; pos_r <= pos_nxt; b1_r <= b1_nxt; hi_r <= hi_nxt;
    ri_r <= ri_nxt; outd_r <= outd_nxt; b0_r <= b0_nxt; pos_ok_r <= pos_ok_nxt;
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled item changed");
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLEAR) |-> (ph_r != PH_IDLE)) else $error("clear without transaction");
endmodule
